FILE: rtl/box_table_span_query_macros.svh
// assertion macros for the box table span query block
// no dependencies
`ifndef BOX_TABLE_SPAN_QUERY_MACROS_SVH
`define BOX_TABLE_SPAN_QUERY_MACROS_SVH
// concurrent check on clk, quiet during reset
`define BTSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition on one edge implies a property on the next, quiet during reset
`define BTSQ_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

FILE: rtl/btsq_pkg.sv
// shared types and constants for the box table span query block
// no dependencies
`default_nettype none
package btsq_pkg;
    localparam int MaxBoxes  = 64;
    localparam int CoordBits = 48;
    localparam int IdxBits   = $clog2(MaxBoxes);
    localparam int CntBits   = 7;

    typedef logic signed [CoordBits-1:0] coord_t;
    typedef logic [IdxBits-1:0]          idx_t;
    typedef logic [CntBits-1:0]          cnt_t;

    typedef enum logic [2:0] {
        FUNC_CLEAR  = 3'd0,
        FUNC_APPEND = 3'd1,
        FUNC_COUNT  = 3'd2,
        FUNC_TEST   = 3'd3,
        FUNC_SPAN   = 3'd4,
        FUNC_EXT    = 3'd5
    } func_t;

    // compare unit request and response
    typedef struct packed {
        coord_t val;
        coord_t lo;
        coord_t hi;
    } cmp_req_t;

    typedef struct packed {
        logic in_range;
        logic below_lo;
        logic above_hi;
    } cmp_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/box_table_span_query.sv
// top level of the box table span query block: sequencer, store and compare unit
// depends on btsq_pkg, btsq_store, btsq_cmp and box_table_span_query_macros.svh
//
//  channel | dir | tdata (low bit up)                                 | tuser/tlast
//  s_axis  | in  | func,lo_x,lo_y,lo_z,hi_x,hi_y,hi_z,axis,probe,ext  | -
//  m_axis  | out | status,found,span_lo,span_hi,box_count,out_axis     | tlast = last
//
// clear, append, count and no-op items go from dispatch straight to the output state;
// a test runs one table pass (none on axis 3) and extents run one pass per axis.
// a span runs the first table pass plus up to n+1 extend passes, where n is the box
// count, then gives its result from the wait state; one row a cycle feeds one
// shared compare. the next item is taken in the cycle after the last result goes.
// reset empties the table; results wait in the output register while m_axis_tready
// is low, and no item is taken until the last result has gone.
`default_nettype none
module box_table_span_query (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // func[2:0] lo_x lo_y lo_z hi_x hi_y hi_z axis[1:0] probe ext_mode, padded to 344
    input  wire  [343:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status found span_lo span_hi box_count[6:0] out_axis[1:0], padded to 112
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import btsq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DISPATCH, ST_SCAN, ST_WAIT, ST_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] func_reg;
    logic [1:0] axis_reg;
    coord_t probe_reg;
    cnt_t total_reg;
    logic [6:0] idx_reg;      // scan position, may equal the count
    logic [1:0] phase_reg;    // 0 first pass, 1 extend pass
    logic [1:0] ext_ax_reg;
    logic have_reg, cand_reg, ext_reg, hit_reg;
    coord_t s_reg, e_reg, minds_reg, minde_reg, lo_reg, hi_reg;
    logic rd_valid_reg;
    logic [6*CoordBits-1:0] rd_data;
    logic wr_en;
    logic [6*CoordBits-1:0] wr_data;
    cmp_req_t creq;
    cmp_rsp_t crsp;
    coord_t ds, de;
    logic [2:0] in_func;
    logic rd_issue;
    logic [1:0] sel_ax;
    logic o_status;
    cnt_t o_count;

    assign in_func = s_axis_tdata[2:0];
    assign wr_data = s_axis_tdata[3 +: 6*CoordBits];
    assign wr_en = s_axis_tvalid && s_axis_tready && (in_func == FUNC_APPEND)
                   && (total_reg < cnt_t'(MaxBoxes));
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign rd_issue = (state_reg == ST_SCAN) && (idx_reg < total_reg);
    assign sel_ax = (func_reg == FUNC_EXT) ? ext_ax_reg : axis_reg;

    // append refused on a full table, and the count after the operation
    assign o_status = (func_reg == FUNC_APPEND) && (total_reg >= cnt_t'(MaxBoxes));
    assign o_count = (func_reg == FUNC_CLEAR) ? '0 :
                     (func_reg == FUNC_APPEND && !o_status) ? total_reg + cnt_t'(1)
                     : total_reg;

    btsq_store u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(total_reg[IdxBits-1:0]), .wr_data(wr_data),
        .rd_addr(idx_reg[IdxBits-1:0]), .rd_data(rd_data)
    );

    // select edges of the chosen axis from the row read back
    always_comb
    begin
        ds = rd_data[32'(sel_ax)*CoordBits +: CoordBits];
        de = rd_data[(32'(sel_ax)+3)*CoordBits +: CoordBits];
        creq.lo = ds;
        creq.hi = de;
        unique case (func_reg)
            FUNC_SPAN: creq.val = (phase_reg == 2'd0) ? probe_reg : e_reg;
            FUNC_EXT:  creq.val = ds;
            default:   creq.val = probe_reg;
        endcase
        if (func_reg == FUNC_EXT)
        begin
            creq.lo = lo_reg;
            creq.hi = hi_reg;
        end
    end

    btsq_cmp u_cmp (.req(creq), .rsp(crsp));

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            m_axis_tvalid <= 1'b0;
            m_axis_tdata  <= '0;
            m_axis_tlast  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            rd_valid_reg <= rd_issue;
            if (rd_issue)
            begin
                idx_reg <= idx_reg + 7'd1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        func_reg  <= in_func;
                        axis_reg  <= s_axis_tdata[6*CoordBits+4:6*CoordBits+3];
                        probe_reg <= s_axis_tdata[6*CoordBits+5 +: CoordBits];
                        if (in_func == FUNC_COUNT && s_axis_tdata[7*CoordBits+5])
                        begin
                            func_reg <= FUNC_EXT;
                        end
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH:
                begin
                    idx_reg <= '0; phase_reg <= '0; ext_ax_reg <= '0;
                    have_reg <= 1'b0; cand_reg <= 1'b0; ext_reg <= 1'b0;
                    hit_reg <= 1'b0; lo_reg <= '0; hi_reg <= '0;
                    s_reg <= probe_reg; e_reg <= '0;
                    unique case (func_reg)
                        FUNC_CLEAR:
                        begin
                            total_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                        FUNC_APPEND:
                        begin
                            if (!o_status)
                            begin
                                total_reg <= total_reg + cnt_t'(1);
                            end
                            state_reg <= ST_OUT;
                        end
                        FUNC_TEST, FUNC_SPAN:
                        begin
                            state_reg <= (axis_reg == 2'd3) ? ST_OUT : ST_SCAN;
                        end
                        FUNC_EXT:  state_reg <= ST_SCAN;
                        default:   state_reg <= ST_OUT;
                    endcase
                    m_axis_tdata <= {5'b0, 2'b00, o_count, {(2*CoordBits){1'b0}}, 1'b0,
                                     o_status};
                    m_axis_tlast <= 1'b1;
                end
                ST_SCAN:
                begin
                    if (!rd_issue && !rd_valid_reg)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    if (rd_valid_reg)
                    begin
                        unique case (func_reg)
                            FUNC_TEST:
                            begin
                                if (crsp.in_range)
                                begin
                                    hit_reg <= 1'b1;
                                end
                            end
                            FUNC_EXT:
                            begin
                                if (crsp.below_lo)
                                begin
                                    lo_reg <= ds;
                                end
                                else if (crsp.above_hi)
                                begin
                                    hi_reg <= ds;
                                end
                            end
                            default:
                            begin
                                if (phase_reg == 2'd0)
                                begin
                                    if (!have_reg && crsp.in_range)
                                    begin
                                        have_reg <= 1'b1;
                                        s_reg <= probe_reg;
                                        e_reg <= de;
                                    end
                                    else if (!have_reg && crsp.below_lo
                                             && (!cand_reg || ds < minds_reg))
                                    begin
                                        cand_reg <= 1'b1;
                                        minds_reg <= ds;
                                        minde_reg <= de;
                                    end
                                end
                                else if (crsp.in_range)
                                begin
                                    e_reg <= de;
                                    ext_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_WAIT:
                begin
                    idx_reg <= '0;
                    unique case (func_reg)
                        FUNC_TEST:
                        begin
                            m_axis_tdata <= {m_axis_tdata[111:2], hit_reg, m_axis_tdata[0]};
                            state_reg <= ST_OUT;
                        end
                        FUNC_EXT:
                        begin
                            m_axis_tdata <= {5'b0, ext_ax_reg, m_axis_tdata[104:98],
                                             hi_reg, lo_reg, 2'b00};
                            m_axis_tlast <= (ext_ax_reg == 2'd2);
                            state_reg <= ST_OUT;
                        end
                        default:
                        begin
                            if (phase_reg == 2'd0)
                            begin
                                if (have_reg || cand_reg)
                                begin
                                    have_reg <= 1'b1;
                                    if (!have_reg)
                                    begin
                                        s_reg <= minds_reg;
                                        e_reg <= minde_reg;
                                    end
                                    phase_reg <= 2'd1;
                                    ext_reg <= 1'b0;
                                    state_reg <= ST_SCAN;
                                end
                                else
                                begin
                                    state_reg <= ST_OUT;
                                end
                            end
                            else if (ext_reg)
                            begin
                                ext_reg <= 1'b0;
                                state_reg <= ST_SCAN;
                            end
                            else
                            begin
                                m_axis_tdata <= {m_axis_tdata[111:98], e_reg, s_reg, 1'b1,
                                                 m_axis_tdata[0]};
                                state_reg <= ST_OUT;
                            end
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (!m_axis_tvalid)
                    begin
                        m_axis_tvalid <= 1'b1;
                    end
                    else if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        if (func_reg == FUNC_EXT && ext_ax_reg != 2'd2)
                        begin
                            ext_ax_reg <= ext_ax_reg + 2'd1;
                            lo_reg <= '0;
                            hi_reg <= '0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `include "box_table_span_query_macros.svh"
    // no item is taken while a result is still on offer
    `BTSQ_ASSERT(a_no_overlap, m_axis_tvalid |-> !s_axis_tready, "ready while result pending")
    // the count never exceeds the table size
    `BTSQ_ASSERT(a_total_max, total_reg <= cnt_t'(MaxBoxes), "box count overflow")
    // a result stays put while stalled
    `BTSQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
        "result changed under stall")
endmodule
`default_nettype wire

FILE: rtl/btsq_cmp.sv
// shared compare unit: range test of one value against one lo/hi edge pair
// depends on btsq_pkg
`default_nettype none
module btsq_cmp (
    input  wire btsq_pkg::cmp_req_t req,
    output btsq_pkg::cmp_rsp_t      rsp
);
    import btsq_pkg::*;
    // signed compares on the selected edges
    always_comb
    begin
        rsp.below_lo = req.val < req.lo;
        rsp.above_hi = req.val > req.hi;
        rsp.in_range = (req.val >= req.lo) && (req.val < req.hi);
    end
endmodule
`default_nettype wire

FILE: rtl/btsq_store.sv
// box memory: one row of six coordinates per box, registered read
// depends on btsq_pkg
`default_nettype none
module btsq_store (
    input  wire                  clk,
    input  wire                  wr_en,
    input  wire btsq_pkg::idx_t  wr_addr,
    input  wire [6*btsq_pkg::CoordBits-1:0] wr_data,
    input  wire btsq_pkg::idx_t  rd_addr,
    output logic [6*btsq_pkg::CoordBits-1:0] rd_data
);
    import btsq_pkg::*;
    logic [6*CoordBits-1:0] mem [MaxBoxes];
    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end
    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: test/box_table_span_query_check.sv
// checker for the box table span query block: predicts results from accepted items
// and compares them with what leaves m_axis; depends on btsq_pkg
`default_nettype none
module box_table_span_query_check (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    input  wire          s_axis_tready,
    input  wire  [343:0] s_axis_tdata,
    input  wire          m_axis_tvalid,
    input  wire          m_axis_tready,
    input  wire  [111:0] m_axis_tdata,
    input  wire          m_axis_tlast,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import btsq_pkg::*;

    typedef struct {
        logic       status;
        logic       found;
        coord_t     span_lo;
        coord_t     span_hi;
        cnt_t       box_count;
        logic [1:0] out_axis;
        logic       last;
    } answer_t;

    // predicted table: corners lo x,y,z then hi x,y,z
    coord_t  boxes [MaxBoxes][6];
    int      held;
    answer_t answers_due[$];

    function automatic answer_t blank_answer();
        answer_t a;
        a.status    = 1'b0;
        a.found     = 1'b0;
        a.span_lo   = '0;
        a.span_hi   = '0;
        a.box_count = cnt_t'(held);
        a.out_axis  = 2'd0;
        a.last      = 1'b1;
        return a;
    endfunction

    // any box whose [low,high) on the axis holds the probe
    function automatic logic probe_covered(logic [1:0] ax, coord_t p);
        if (ax > 2'd2)
            return 1'b0;
        for (int i = 0; i < held; i++)
            if (p >= boxes[i][ax] && p < boxes[i][ax+3])
                return 1'b1;
        return 1'b0;
    endfunction

    // first covering box or nearest low edge above, then extend the end
    function automatic logic covered_span(logic [1:0] ax, coord_t p,
                                          output coord_t s, output coord_t e);
        logic   hit;
        logic   cand;
        logic   grew;
        coord_t best_lo;
        coord_t best_hi;
        hit  = 1'b0;
        cand = 1'b0;
        s    = p;
        e    = '0;
        best_lo = '0;
        best_hi = '0;
        if (ax > 2'd2)
            return 1'b0;
        for (int i = 0; i < held; i++)
        begin
            if (p >= boxes[i][ax] && p < boxes[i][ax+3])
            begin
                hit = 1'b1;
                e   = boxes[i][ax+3];
                break;
            end
            if (p < boxes[i][ax] && (!cand || boxes[i][ax] < best_lo))
            begin
                cand    = 1'b1;
                best_lo = boxes[i][ax];
                best_hi = boxes[i][ax+3];
            end
        end
        if (!hit && cand)
        begin
            hit = 1'b1;
            s   = best_lo;
            e   = best_hi;
        end
        if (!hit)
            return 1'b0;
        do
        begin
            grew = 1'b0;
            for (int i = 0; i < held; i++)
                if (e >= boxes[i][ax] && e < boxes[i][ax+3])
                begin
                    e    = boxes[i][ax+3];
                    grew = 1'b1;
                end
        end
        while (grew);
        return 1'b1;
    endfunction

    // work out the answers an accepted item causes
    task automatic predict_item(logic [343:0] d);
        logic [2:0] fn;
        logic [1:0] ax;
        coord_t     p;
        answer_t    a;
        coord_t     s;
        coord_t     e;
        coord_t     lo;
        coord_t     hi;
        fn = d[2:0];
        ax = d[292:291];
        p  = d[340:293];
        if (fn == FUNC_CLEAR)
        begin
            held = 0;
            answers_due.push_back(blank_answer());
        end
        else if (fn == FUNC_APPEND)
        begin
            a = blank_answer();
            if (held >= MaxBoxes)
                a.status = 1'b1;
            else
            begin
                for (int j = 0; j < 6; j++)
                    boxes[held][j] = d[3 + 48*j +: 48];
                held++;
                a.box_count = cnt_t'(held);
            end
            answers_due.push_back(a);
        end
        else if ((fn == FUNC_COUNT && d[341]) || fn == FUNC_EXT)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo = '0;
                hi = '0;
                for (int i = 0; i < held; i++)
                    if (boxes[i][k] < lo)
                        lo = boxes[i][k];
                    else if (boxes[i][k] > hi)
                        hi = boxes[i][k];
                a = blank_answer();
                a.span_lo  = lo;
                a.span_hi  = hi;
                a.out_axis = k[1:0];
                a.last     = (k == 2);
                answers_due.push_back(a);
            end
        end
        else if (fn == FUNC_TEST)
        begin
            a = blank_answer();
            a.found = probe_covered(ax, p);
            answers_due.push_back(a);
        end
        else if (fn == FUNC_SPAN)
        begin
            a = blank_answer();
            a.found = covered_span(ax, p, s, e);
            if (a.found)
            begin
                a.span_lo = s;
                a.span_hi = e;
            end
            answers_due.push_back(a);
        end
        else
            answers_due.push_back(blank_answer());
    endtask

    task automatic compare_answer(logic [111:0] d, logic lst);
        answer_t x;
        if (answers_due.size() == 0)
        begin
            $error("result with nothing expected: tdata %h", d);
            fail_count++;
            return;
        end
        x = answers_due.pop_front();
        if (d[0] !== x.status)
        begin
            $error("status: expected %0d, got %0d", x.status, d[0]);
            fail_count++;
        end
        if (d[1] !== x.found)
        begin
            $error("found: expected %0d, got %0d", x.found, d[1]);
            fail_count++;
        end
        if (d[49:2] !== x.span_lo)
        begin
            $error("span_lo: expected %h, got %h", x.span_lo, d[49:2]);
            fail_count++;
        end
        if (d[97:50] !== x.span_hi)
        begin
            $error("span_hi: expected %h, got %h", x.span_hi, d[97:50]);
            fail_count++;
        end
        if (d[104:98] !== x.box_count)
        begin
            $error("box_count: expected %0d, got %0d", x.box_count, d[104:98]);
            fail_count++;
        end
        if (d[106:105] !== x.out_axis)
        begin
            $error("out_axis: expected %0d, got %0d", x.out_axis, d[106:105]);
            fail_count++;
        end
        if (lst !== x.last)
        begin
            $error("last: expected %0d, got %0d", x.last, lst);
            fail_count++;
        end
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            answers_due.delete();
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_answer(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tdata);
            pending = answers_due.size();
        end
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end
endmodule
`default_nettype wire

FILE: test/box_table_span_query_test.sv
// top of the box table span query testbench: clock, reset, item stimulus,
// result back-pressure and verdict; depends on btsq_pkg, the block and its checker
`default_nettype none
module box_table_span_query_test;
    timeunit 1ns;
    timeprecision 1ps;
    import btsq_pkg::*;

    localparam logic [2:0] FuncNopLow  = 3'd6;
    localparam logic [2:0] FuncNopHigh = 3'd7;
    localparam logic [1:0] AxisNone    = 2'd3;
    localparam int         StallLimit  = 40000;
    localparam coord_t     CoordMin    = {1'b1, {(CoordBits-1){1'b0}}};
    localparam coord_t     CoordMax    = {1'b0, {(CoordBits-1){1'b1}}};

    typedef struct {
        logic [2:0] func;
        coord_t     corner [6];
        logic [1:0] axis;
        coord_t     probe;
        logic       ext_mode;
    } request_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [343:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;
    int           fail_count;
    int           pending;
    int           idle_cycles;
    int           sent;

    box_table_span_query u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    box_table_span_query_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly small coordinates so boxes overlap, sometimes anything
    function automatic coord_t pick_coord();
        coord_t c;
        if ($urandom_range(0, 6) == 0)
            c = coord_t'({$urandom, $urandom});
        else
        begin
            c = coord_t'(int'($urandom_range(0, 128)) - 64) <<< 16;
            if ($urandom_range(0, 3) == 0)
                c = c + coord_t'($urandom_range(0, 65535));
        end
        return c;
    endfunction

    function automatic request_t make_request(logic [2:0] fn);
        request_t r;
        r.func = fn;
        for (int j = 0; j < 3; j++)
        begin
            r.corner[j] = pick_coord();
            if ($urandom_range(0, 7) == 0)
                r.corner[j+3] = pick_coord();
            else
                r.corner[j+3] = r.corner[j] + (coord_t'($urandom_range(1, 24)) <<< 16);
        end
        r.axis     = ($urandom_range(0, 9) == 0) ? AxisNone : 2'($urandom_range(0, 2));
        r.probe    = pick_coord();
        r.ext_mode = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic request_t box_request(coord_t lo, coord_t hi);
        request_t r;
        r = make_request(FUNC_APPEND);
        for (int j = 0; j < 3; j++)
        begin
            r.corner[j]   = lo;
            r.corner[j+3] = hi;
        end
        return r;
    endfunction

    function automatic request_t query_request(logic [2:0] fn, logic [1:0] ax, coord_t p);
        request_t r;
        r = make_request(fn);
        r.axis  = ax;
        r.probe = p;
        return r;
    endfunction

    // pick a random operation, weighted towards filling the table
    function automatic request_t random_request(bit allow_clear);
        int w;
        w = $urandom_range(0, 99);
        if (allow_clear && w < 4)
            return make_request(FUNC_CLEAR);
        if (w < 55)
            return make_request(FUNC_APPEND);
        if (w < 70)
            return make_request(FUNC_SPAN);
        if (w < 82)
            return make_request(FUNC_TEST);
        if (w < 90)
            return make_request(FUNC_COUNT);
        if (w < 96)
            return make_request(FUNC_EXT);
        return make_request($urandom_range(0, 1) ? FuncNopLow : FuncNopHigh);
    endfunction

    // offer one item and hold it until taken, then maybe go quiet for a while
    task automatic offer(request_t r);
        int gap;
        s_axis_tdata  <= {2'b00, r.ext_mode, r.probe, r.axis, r.corner[5], r.corner[4],
                          r.corner[3], r.corner[2], r.corner[1], r.corner[0], r.func};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
        gap = ((sent / 20) % 3 == 1) ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side back-pressure, with stretches of none
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            stall = ((taken / 25) % 3 == 2) ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("box_table_span_query verification failed");
            $finish;
        end
    end

    initial
    begin
        idle_cycles   = 0;
        sent          = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table cases
        offer(make_request(FUNC_CLEAR));
        offer(query_request(FUNC_TEST, 2'd0, '0));
        offer(query_request(FUNC_SPAN, 2'd1, CoordMin));
        offer(make_request(FUNC_EXT));
        offer(make_request(FuncNopLow));
        offer(make_request(FuncNopHigh));
        // extreme and unnormalised boxes
        offer(box_request(CoordMin, CoordMax));
        offer(box_request(coord_t'(10) <<< 16, coord_t'(-5) <<< 16));
        offer(box_request(coord_t'(20) <<< 16, coord_t'(30) <<< 16));
        offer(box_request(coord_t'(28) <<< 16, coord_t'(40) <<< 16));
        // membership on every axis, including the missing one
        offer(query_request(FUNC_TEST, 2'd0, CoordMax));
        offer(query_request(FUNC_TEST, 2'd1, CoordMin));
        offer(query_request(FUNC_TEST, 2'd2, coord_t'(25) <<< 16));
        offer(query_request(FUNC_TEST, AxisNone, '0));
        // spans: inside, ahead of a box, past everything, missing axis
        offer(query_request(FUNC_SPAN, 2'd2, CoordMin));
        offer(query_request(FUNC_SPAN, 2'd0, CoordMax));
        offer(make_request(FUNC_CLEAR));
        offer(box_request(coord_t'(20) <<< 16, coord_t'(30) <<< 16));
        offer(box_request(coord_t'(28) <<< 16, coord_t'(40) <<< 16));
        offer(query_request(FUNC_SPAN, 2'd1, coord_t'(21) <<< 16));
        offer(query_request(FUNC_SPAN, 2'd0, '0));
        offer(query_request(FUNC_SPAN, 2'd2, coord_t'(45) <<< 16));
        offer(query_request(FUNC_SPAN, AxisNone, '0));
        begin
            request_t r;
            r = make_request(FUNC_COUNT);
            r.ext_mode = 1'b0;
            offer(r);
            r.ext_mode = 1'b1;
            offer(r);
        end

        // hold off until every result is back
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        // fill past capacity, then mix with clears
        offer(make_request(FUNC_CLEAR));
        repeat (66) offer(make_request(FUNC_APPEND));
        repeat (50) offer(random_request(1'b1));
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("box_table_span_query verification clean");
        else
            $display("box_table_span_query verification failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/btsq_pkg.sv
rtl/btsq_cmp.sv
rtl/btsq_store.sv
rtl/box_table_span_query.sv
test/box_table_span_query_check.sv
test/box_table_span_query_test.sv
